// ===== hdl/two_axis_stepper_move_controller_assert.svh =====
// assertion macros for the two-axis stepper move controller
// used by the top level; expects aclk and aresetn in the including scope
`ifndef TWO_AXIS_STEPPER_MOVE_CONTROLLER_ASSERT_SVH
`define TWO_AXIS_STEPPER_MOVE_CONTROLLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// condition in the same cycle
`define TASMC_ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("tasmc assertion failed");
// condition in the following cycle
`define TASMC_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("tasmc assertion failed");
`else
`define TASMC_ASSERT_SAME(lbl, pre, post)
`define TASMC_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== hdl/tasmc_pkg.sv =====
// types and codes for the two-axis stepper move controller
// no dependencies; used by tasmc_ctrl and the top level
package tasmc_pkg;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    localparam int unsigned CFG_W      = 10;
    localparam int unsigned CNT_W      = 20;
    localparam int unsigned LIMIT_W    = 18;
    localparam int unsigned DIST_RAW_W = 11;

    typedef enum logic [2:0] {
        CMD_VMOVE   = 3'd0,
        CMD_HMOVE   = 3'd1,
        CMD_SUCTION = 3'd2,
        CMD_RESET   = 3'd3,
        CMD_STOP    = 3'd4
    } cmd_kind_t;

    typedef enum logic [1:0] {
        REG_STEP_DIVIDER = 2'd0,
        REG_STEPS_PER_MM = 2'd1,
        REG_MAX_DISTANCE = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_INITIAL    = 2'd0,
        MODE_STOPPED    = 2'd1,
        MODE_VERTICAL   = 2'd2,
        MODE_HORIZONTAL = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PEND_NONE       = 2'd0,
        PEND_STOP       = 2'd1,
        PEND_VERTICAL   = 2'd2,
        PEND_HORIZONTAL = 2'd3
    } pend_t;

    typedef struct packed {
        logic [7:0] step_divider;
        logic [7:0] steps_per_mm;
        logic [9:0] max_distance;
    } cfg_t;

    localparam logic [7:0] STEP_DIVIDER_RST = 8'd8;
    localparam logic [7:0] STEPS_PER_MM_RST = 8'd25;
    localparam logic [9:0] MAX_DISTANCE_RST = 10'd100;

    typedef struct packed {
        logic       opcode;
        logic [2:0] command_kind;
        logic       move_positive;
        logic [3:0] hundreds_digit;
        logic [3:0] tens_digit;
        logic [3:0] units_digit;
        logic [4:0] suction_request;
        logic       vertical_top_hit;
        logic       vertical_bottom_hit;
        logic       horizontal_top_hit;
        logic       horizontal_bottom_hit;
    } in_item_t;

    typedef struct packed {
        logic       driver_enable;
        logic       x_direction;
        logic       y_direction;
        logic       x_step_pin;
        logic       y_step_pin;
        logic [4:0] suction_outputs;
        logic       busy_res;
        logic       ready_reply;
    } out_item_t;

endpackage

// ===== hdl/two_axis_stepper_move_controller.sv =====
// top level of the two-axis stepper move controller
// depends on tasmc_pkg, tasmc_ctrl and the assertion macro header
//
// Each input word is a timer tick or a decoded command and yields exactly one
// result word with the driver, direction, step pin and suction levels plus busy
// and ready flags. One word is taken per clock cycle while the result side does
// not stall; each word passes the input register, then the result register.
// The update between the two registers is a single pass: the distance clamp,
// a 10 by 8 bit multiply for the step limit and one compare. Register writes
// on the cfg channel are always taken and should only be issued while idle.
`include "two_axis_stepper_move_controller_assert.svh"
module two_axis_stepper_move_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tasmc_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tasmc_pkg::out_item_t m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [tasmc_pkg::CFG_W-1:0] cfg_data
);

    tasmc_pkg::cfg_t      cfg_reg;
    logic                 in_valid_reg;
    tasmc_pkg::in_item_t  in_data_reg;
    logic                 m_valid_reg;
    tasmc_pkg::out_item_t m_data_reg;
    tasmc_pkg::out_item_t result;
    logic                 advance;

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_divider <= tasmc_pkg::STEP_DIVIDER_RST;
            cfg_reg.steps_per_mm <= tasmc_pkg::STEPS_PER_MM_RST;
            cfg_reg.max_distance <= tasmc_pkg::MAX_DISTANCE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                tasmc_pkg::REG_STEP_DIVIDER: cfg_reg.step_divider <= cfg_data[7:0];
                tasmc_pkg::REG_STEPS_PER_MM: cfg_reg.steps_per_mm <= cfg_data[7:0];
                tasmc_pkg::REG_MAX_DISTANCE: cfg_reg.max_distance <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= result;
        end
    end

    tasmc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .cfg     (cfg_reg),
        .item    (in_data_reg),
        .result  (result)
    );

    // a ready reply never comes with a running move
    `TASMC_ASSERT_SAME(a_ready_not_busy, m_valid_reg && m_data_reg.ready_reply, !m_data_reg.busy_res)
    // a held input word is not dropped while the result side stalls
    `TASMC_ASSERT_NEXT(a_input_held, in_valid_reg && !advance, in_valid_reg)
    // a full input stage behind a stalled result blocks new words
    `TASMC_ASSERT_SAME(a_no_overrun, in_valid_reg && m_valid_reg && !m_ready, !s_ready)

endmodule

// ===== hdl/tasmc_ctrl.sv =====
// move control state and per-word update for the stepper controller
// depends on tasmc_pkg; the state advances only when step_en is high
module tasmc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  tasmc_pkg::cfg_t     cfg,
    input  tasmc_pkg::in_item_t item,
    output tasmc_pkg::out_item_t result
);

    tasmc_pkg::mode_t                 mode_reg, mode_next;
    tasmc_pkg::pend_t                 pend_reg, pend_next;
    logic                             busy_reg, busy_next;
    logic [9:0]                       target_reg, target_next;
    logic                             travel_pos_reg, travel_pos_next;
    logic [tasmc_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [7:0]                       tick_div_reg, tick_div_next;
    logic [1:0]                       levels_reg, levels_next;
    logic [4:0]                       suction_reg, suction_next;
    logic [1:0]                       dir_reg, dir_next;
    logic                             ready_next;

    logic [tasmc_pkg::DIST_RAW_W-1:0] dist_raw;
    logic [tasmc_pkg::LIMIT_W-1:0]    limit;
    logic                             is_cmd;
    logic                             is_reset;
    logic                             dir_pos;
    logic                             hit_top;
    logic                             hit_bottom;
    logic                             done;

    assign dist_raw = tasmc_pkg::DIST_RAW_W'(item.hundreds_digit) * 11'd100
                    + tasmc_pkg::DIST_RAW_W'(item.tens_digit) * 11'd10
                    + tasmc_pkg::DIST_RAW_W'(item.units_digit);
    assign is_cmd   = (item.opcode == tasmc_pkg::OP_COMMAND);
    assign is_reset = is_cmd && (item.command_kind == tasmc_pkg::CMD_RESET);

    // next state: command latch or tick, then move control unless the command is a reset
    always_comb begin
        mode_next       = mode_reg;
        pend_next       = pend_reg;
        busy_next       = busy_reg;
        target_next     = target_reg;
        travel_pos_next = travel_pos_reg;
        count_next      = count_reg;
        tick_div_next   = tick_div_reg;
        levels_next     = levels_reg;
        suction_next    = suction_reg;
        dir_next        = dir_reg;
        ready_next      = 1'b0;
        limit           = '0;
        dir_pos         = 1'b0;
        hit_top         = 1'b0;
        hit_bottom      = 1'b0;
        done            = 1'b0;

        if (is_cmd) begin
            case (item.command_kind)
                tasmc_pkg::CMD_VMOVE, tasmc_pkg::CMD_HMOVE: begin
                    target_next = (dist_raw > {1'b0, cfg.max_distance})
                                ? cfg.max_distance : dist_raw[9:0];
                    travel_pos_next = item.move_positive;
                    pend_next = (item.command_kind == tasmc_pkg::CMD_VMOVE)
                              ? tasmc_pkg::PEND_VERTICAL : tasmc_pkg::PEND_HORIZONTAL;
                end
                tasmc_pkg::CMD_SUCTION: begin
                    suction_next = item.suction_request;
                    pend_next    = tasmc_pkg::PEND_STOP;
                    ready_next   = !busy_reg;
                end
                tasmc_pkg::CMD_RESET: begin
                    mode_next       = tasmc_pkg::MODE_INITIAL;
                    pend_next       = tasmc_pkg::PEND_NONE;
                    busy_next       = 1'b0;
                    target_next     = '0;
                    travel_pos_next = 1'b0;
                    count_next      = '0;
                    tick_div_next   = '0;
                    levels_next     = 2'b11;
                    suction_next    = '0;
                    dir_next        = '0;
                end
                default: begin
                    pend_next = tasmc_pkg::PEND_STOP;
                end
            endcase
        end else begin
            if (({1'b0, tick_div_reg} + 9'd1) >= {1'b0, cfg.step_divider}) begin
                tick_div_next = '0;
                // the moving axis toggles and counts, an idle axis is driven high
                if (busy_reg && mode_reg == tasmc_pkg::MODE_VERTICAL) begin
                    levels_next[1] = !levels_reg[1];
                    if (count_reg != '1) begin
                        count_next = count_reg + tasmc_pkg::CNT_W'(1);
                    end
                end else begin
                    levels_next[1] = 1'b1;
                end
                if (busy_reg && mode_reg == tasmc_pkg::MODE_HORIZONTAL) begin
                    levels_next[0] = !levels_reg[0];
                    if (count_reg != '1) begin
                        count_next = count_reg + tasmc_pkg::CNT_W'(1);
                    end
                end else begin
                    levels_next[0] = 1'b1;
                end
            end else begin
                tick_div_next = tick_div_reg + 8'd1;
            end
        end

        if (!is_reset) begin
            if (!busy_next && pend_next != tasmc_pkg::PEND_NONE) begin
                case (pend_next)
                    tasmc_pkg::PEND_VERTICAL: begin
                        mode_next   = tasmc_pkg::MODE_VERTICAL;
                        busy_next   = 1'b1;
                        count_next  = '0;
                        dir_next[1] = travel_pos_next;
                    end
                    tasmc_pkg::PEND_HORIZONTAL: begin
                        mode_next   = tasmc_pkg::MODE_HORIZONTAL;
                        busy_next   = 1'b1;
                        count_next  = '0;
                        dir_next[0] = travel_pos_next;
                    end
                    default: begin
                        mode_next  = tasmc_pkg::MODE_STOPPED;
                        ready_next = 1'b1;
                    end
                endcase
                pend_next = tasmc_pkg::PEND_NONE;
            end

            limit = tasmc_pkg::LIMIT_W'(target_next) * tasmc_pkg::LIMIT_W'(cfg.steps_per_mm);
            if (mode_next == tasmc_pkg::MODE_VERTICAL) begin
                dir_pos    = dir_next[1];
                hit_top    = item.vertical_top_hit;
                hit_bottom = item.vertical_bottom_hit;
            end else begin
                dir_pos    = dir_next[0];
                hit_top    = item.horizontal_top_hit;
                hit_bottom = item.horizontal_bottom_hit;
            end
            // half the toggle count is the number of full steps
            done = ({1'b0, count_next[tasmc_pkg::CNT_W-1:1]} >= limit)
                || (dir_pos && hit_top) || (!dir_pos && hit_bottom);

            if (busy_next && done) begin
                busy_next  = 1'b0;
                count_next = '0;
                if (pend_next != tasmc_pkg::PEND_VERTICAL
                    && pend_next != tasmc_pkg::PEND_HORIZONTAL) begin
                    pend_next  = tasmc_pkg::PEND_NONE;
                    mode_next  = tasmc_pkg::MODE_STOPPED;
                    ready_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        result.driver_enable   = busy_next;
        result.x_direction     = dir_next[0];
        result.y_direction     = dir_next[1];
        result.x_step_pin      = levels_next[0];
        result.y_step_pin      = levels_next[1];
        result.suction_outputs = suction_next;
        result.busy_res        = busy_next;
        result.ready_reply     = ready_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= tasmc_pkg::MODE_INITIAL;
            pend_reg       <= tasmc_pkg::PEND_NONE;
            busy_reg       <= 1'b0;
            target_reg     <= '0;
            travel_pos_reg <= 1'b0;
            count_reg      <= '0;
            tick_div_reg   <= '0;
            levels_reg     <= 2'b11;
            suction_reg    <= '0;
            dir_reg        <= '0;
        end else if (step_en) begin
            mode_reg       <= mode_next;
            pend_reg       <= pend_next;
            busy_reg       <= busy_next;
            target_reg     <= target_next;
            travel_pos_reg <= travel_pos_next;
            count_reg      <= count_next;
            tick_div_reg   <= tick_div_next;
            levels_reg     <= levels_next;
            suction_reg    <= suction_next;
            dir_reg        <= dir_next;
        end
    end

endmodule
